@@ hdl/svpm_pkg.sv @@
package svpm_pkg;

    localparam int STORE_PAGES    = 64;
    localparam int PAGE_IDX_BITS  = $clog2(STORE_PAGES);
    localparam int WORD_BITS      = 10;
    localparam int STORE_AW       = PAGE_IDX_BITS + WORD_BITS;
    localparam int PPN_BITS       = 22;
    localparam int FREE_BITS      = 23;
    localparam int COUNT_BITS     = 7;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [WORD_BITS-1:0] LAST_WORD = {WORD_BITS{1'b1}};

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STORE_BASE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROOT_TABLE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FREE_START = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FREE_END   = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_VA_UNALIGNED = 2'd1,
        STAT_PA_UNALIGNED = 2'd2,
        STAT_NO_MEM       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_ZERO,
        S_ROOT_WR,
        S_LEAF_WR
    } state_t;

    typedef struct packed {
        logic                 wr_en;
        logic [FREE_BITS-1:0] wr_page;
        logic [WORD_BITS-1:0] wr_word;
        logic [31:0]          wr_data;
        logic                 rd_en;
        logic [FREE_BITS-1:0] rd_page;
        logic [WORD_BITS-1:0] rd_word;
    } store_req_t;

    // page lies inside the store window
    function automatic logic slot_ok(input logic [FREE_BITS-1:0] page,
                                     input logic [PPN_BITS-1:0]  base);
        logic [FREE_BITS:0] rel;
        rel = {1'b0, page} - {2'b00, base};
        return !rel[FREE_BITS] && (rel[FREE_BITS-1:0] < FREE_BITS'(STORE_PAGES));
    endfunction

    function automatic logic [STORE_AW-1:0] slot_addr(input logic [FREE_BITS-1:0] page,
                                                      input logic [PPN_BITS-1:0]  base,
                                                      input logic [WORD_BITS-1:0] word);
        logic [FREE_BITS:0] rel;
        rel = {1'b0, page} - {2'b00, base};
        return {rel[PAGE_IDX_BITS-1:0], word};
    endfunction

endpackage

@@ hdl/svpm_page_store.sv @@
module svpm_page_store
(
    input  logic                            clk,
    input  logic [svpm_pkg::PPN_BITS-1:0]   base_page,
    input  svpm_pkg::store_req_t            req,
    output logic [31:0]                     rd_data
);

    logic [31:0] mem [(1 << svpm_pkg::STORE_AW)];
    logic [31:0] mem_q_reg;
    logic        rd_hit_reg;

    logic wr_hit;
    logic rd_hit;

    assign wr_hit = req.wr_en && svpm_pkg::slot_ok(req.wr_page, base_page);
    assign rd_hit = svpm_pkg::slot_ok(req.rd_page, base_page);

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[svpm_pkg::slot_addr(req.wr_page, base_page, req.wr_word)] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg  <= mem[svpm_pkg::slot_addr(req.rd_page, base_page, req.rd_word)];
            rd_hit_reg <= rd_hit;
        end
    end

    // pages outside the store read as zero
    assign rd_data = rd_hit_reg ? mem_q_reg : 32'd0;

endmodule

@@ hdl/sv32_page_mapper.sv @@
// channel   direction  handshake            fields
// config    in         cfg_wr_en            cfg_addr, cfg_data
// command   in         start & !busy        cmd, virt_addr, phys_addr, perm_flags, page_count
// result    out        done (one cycle)     status, result_page, table_created, leaf_entry
//
// Unaligned maps and failing or zero-page allocates report on the cycle after start.
// Map with an existing table: root read, check, leaf write.
// Each allocated page inside the store is zeroed one word per cycle
// through the single store write port; pages outside the store are passed with no write.
// Reset: control idle; config base 0, root 0, free 1..64; store is undefined until written.
// The receiver cannot stall: done pulses for one cycle while busy is already low.
module sv32_page_mapper
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [svpm_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
    input  logic [svpm_pkg::FREE_BITS-1:0]      cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [31:0]                         virt_addr,
    input  logic [31:0]                         phys_addr,
    input  logic [9:0]                          perm_flags,
    input  logic [svpm_pkg::COUNT_BITS-1:0]     page_count,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [svpm_pkg::PPN_BITS-1:0]       result_page,
    output logic                                table_created,
    output logic [31:0]                         leaf_entry
);

    localparam int FB = svpm_pkg::FREE_BITS;
    localparam int PB = svpm_pkg::PPN_BITS;
    localparam int WB = svpm_pkg::WORD_BITS;
    localparam int CB = svpm_pkg::COUNT_BITS;

    svpm_pkg::state_t   state_reg, state_next;
    logic [PB-1:0]      store_base_reg, store_base_next;
    logic [PB-1:0]      root_page_reg, root_page_next;
    logic [FB-1:0]      free_end_reg, free_end_next;
    logic [FB-1:0]      free_ptr_reg, free_ptr_next;

    logic               alloc_reg, alloc_next;
    logic [WB-1:0]      vpn1_reg, vpn1_next;
    logic [WB-1:0]      vpn0_reg, vpn0_next;
    logic [31:0]        leaf_reg, leaf_next;
    logic [PB-1:0]      table_page_reg, table_page_next;
    logic               created_reg, created_next;
    logic [FB-1:0]      first_reg, first_next;
    logic [FB-1:0]      zpage_reg, zpage_next;
    logic [WB-1:0]      zword_reg, zword_next;
    logic [CB-1:0]      zleft_reg, zleft_next;

    logic               done_reg, done_next;
    svpm_pkg::status_t  status_reg, status_next;
    logic [PB-1:0]      result_page_reg, result_page_next;
    logic               table_created_reg, table_created_next;
    logic [31:0]        leaf_entry_reg, leaf_entry_next;

    svpm_pkg::store_req_t req;
    logic [31:0]          rd_data;
    logic [FB:0]          alloc_sum;
    logic [FB:0]          one_sum;
    logic                 zero_hit;
    logic                 page_end;

    svpm_page_store u_store
    (
        .clk       (clk),
        .base_page (store_base_reg),
        .req       (req),
        .rd_data   (rd_data)
    );

    assign alloc_sum = {1'b0, free_ptr_reg} + {{(FB + 1 - CB){1'b0}}, page_count};
    assign one_sum   = {1'b0, free_ptr_reg} + {{FB{1'b0}}, 1'b1};
    assign zero_hit  = svpm_pkg::slot_ok(zpage_reg, store_base_reg);
    assign page_end  = !zero_hit || (zword_reg == svpm_pkg::LAST_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= svpm_pkg::S_IDLE;
            store_base_reg    <= '0;
            root_page_reg     <= '0;
            free_end_reg      <= FB'(64);
            free_ptr_reg      <= FB'(1);
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            store_base_reg    <= store_base_next;
            root_page_reg     <= root_page_next;
            free_end_reg      <= free_end_next;
            free_ptr_reg      <= free_ptr_next;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alloc_reg         <= alloc_next;
        vpn1_reg          <= vpn1_next;
        vpn0_reg          <= vpn0_next;
        leaf_reg          <= leaf_next;
        table_page_reg    <= table_page_next;
        created_reg       <= created_next;
        first_reg         <= first_next;
        zpage_reg         <= zpage_next;
        zword_reg         <= zword_next;
        zleft_reg         <= zleft_next;
        status_reg        <= status_next;
        result_page_reg   <= result_page_next;
        table_created_reg <= table_created_next;
        leaf_entry_reg    <= leaf_entry_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        store_base_next    = store_base_reg;
        root_page_next     = root_page_reg;
        free_end_next      = free_end_reg;
        free_ptr_next      = free_ptr_reg;
        alloc_next         = alloc_reg;
        vpn1_next          = vpn1_reg;
        vpn0_next          = vpn0_reg;
        leaf_next          = leaf_reg;
        table_page_next    = table_page_reg;
        created_next       = created_reg;
        first_next         = first_reg;
        zpage_next         = zpage_reg;
        zword_next         = zword_reg;
        zleft_next         = zleft_reg;
        done_next          = 1'b0;
        status_next        = status_reg;
        result_page_next   = result_page_reg;
        table_created_next = table_created_reg;
        leaf_entry_next    = leaf_entry_reg;
        req                = '0;

        unique case (state_reg)
            svpm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    status_next        = svpm_pkg::STAT_OK;
                    result_page_next   = '0;
                    table_created_next = 1'b0;
                    leaf_entry_next    = '0;
                    alloc_next         = cmd;
                    created_next       = 1'b0;
                    if (cmd == svpm_pkg::CMD_ALLOC)
                    begin
                        if (alloc_sum > {1'b0, free_end_reg})
                        begin
                            status_next = svpm_pkg::STAT_NO_MEM;
                            done_next   = 1'b1;
                        end
                        else if (page_count == '0)
                        begin
                            result_page_next = free_ptr_reg[PB-1:0];
                            done_next        = 1'b1;
                        end
                        else
                        begin
                            first_next    = free_ptr_reg;
                            zpage_next    = free_ptr_reg;
                            zword_next    = '0;
                            zleft_next    = page_count;
                            free_ptr_next = alloc_sum[FB-1:0];
                            state_next    = svpm_pkg::S_ZERO;
                        end
                    end
                    else if (virt_addr[11:0] != 12'd0)
                    begin
                        status_next = svpm_pkg::STAT_VA_UNALIGNED;
                        done_next   = 1'b1;
                    end
                    else if (phys_addr[11:0] != 12'd0)
                    begin
                        status_next = svpm_pkg::STAT_PA_UNALIGNED;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        vpn1_next  = virt_addr[31:22];
                        vpn0_next  = virt_addr[21:12];
                        leaf_next  = {2'b00, phys_addr[31:12], perm_flags | 10'd1};
                        state_next = svpm_pkg::S_ROOT_RD;
                    end
                end
            end

            svpm_pkg::S_ROOT_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_page = {1'b0, root_page_reg};
                req.rd_word = vpn1_reg;
                state_next  = svpm_pkg::S_ROOT_CHK;
            end

            svpm_pkg::S_ROOT_CHK:
            begin
                if (rd_data[0])
                begin
                    table_page_next = rd_data[31:10];
                    state_next      = svpm_pkg::S_LEAF_WR;
                end
                else if (one_sum > {1'b0, free_end_reg})
                begin
                    status_next = svpm_pkg::STAT_NO_MEM;
                    done_next   = 1'b1;
                    state_next  = svpm_pkg::S_IDLE;
                end
                else
                begin
                    first_next      = free_ptr_reg;
                    zpage_next      = free_ptr_reg;
                    zword_next      = '0;
                    zleft_next      = CB'(1);
                    free_ptr_next   = one_sum[FB-1:0];
                    table_page_next = free_ptr_reg[PB-1:0];
                    created_next    = 1'b1;
                    state_next      = svpm_pkg::S_ZERO;
                end
            end

            svpm_pkg::S_ZERO:
            begin
                req.wr_en   = zero_hit;
                req.wr_page = zpage_reg;
                req.wr_word = zword_reg;
                req.wr_data = '0;
                zword_next  = zword_reg + WB'(1);
                if (page_end)
                begin
                    zword_next = '0;
                    zpage_next = zpage_reg + FB'(1);
                    zleft_next = zleft_reg - CB'(1);
                    if (zleft_reg == CB'(1))
                    begin
                        if (alloc_reg == svpm_pkg::CMD_ALLOC)
                        begin
                            result_page_next = first_reg[PB-1:0];
                            done_next        = 1'b1;
                            state_next       = svpm_pkg::S_IDLE;
                        end
                        else
                        begin
                            state_next = svpm_pkg::S_ROOT_WR;
                        end
                    end
                end
            end

            svpm_pkg::S_ROOT_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_page = {1'b0, root_page_reg};
                req.wr_word = vpn1_reg;
                req.wr_data = {table_page_reg, 10'd1};
                state_next  = svpm_pkg::S_LEAF_WR;
            end

            svpm_pkg::S_LEAF_WR:
            begin
                req.wr_en          = 1'b1;
                req.wr_page        = {1'b0, table_page_reg};
                req.wr_word        = vpn0_reg;
                req.wr_data        = leaf_reg;
                result_page_next   = table_page_reg;
                table_created_next = created_reg;
                leaf_entry_next    = leaf_reg;
                done_next          = 1'b1;
                state_next         = svpm_pkg::S_IDLE;
            end

            default:
            begin
                state_next = svpm_pkg::S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                svpm_pkg::CFG_STORE_BASE: store_base_next = cfg_data[PB-1:0];
                svpm_pkg::CFG_ROOT_TABLE: root_page_next  = cfg_data[PB-1:0];
                svpm_pkg::CFG_FREE_START: free_ptr_next   = cfg_data;
                svpm_pkg::CFG_FREE_END:   free_end_next   = cfg_data;
                default:                  free_end_next   = free_end_reg;
            endcase
        end
    end

    assign busy          = (state_reg != svpm_pkg::S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign result_page   = result_page_reg;
    assign table_created = table_created_reg;
    assign leaf_entry    = leaf_entry_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int WORDS_PER_PAGE = 1 << svpm_pkg::WORD_BITS;
    localparam int RST_FREE_START = 1;
    localparam int RST_FREE_END   = 64;
    localparam int MAX_PAGE       = (1 << svpm_pkg::PPN_BITS) - 1;
    localparam int MAX_FREE       = 1 << svpm_pkg::PPN_BITS;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct packed {
        logic                            op;
        logic [31:0]                     va;
        logic [31:0]                     pa;
        logic [9:0]                      flags;
        logic [svpm_pkg::COUNT_BITS-1:0] count;
    } map_cmd_t;

    typedef struct packed {
        svpm_pkg::status_t             st;
        logic [svpm_pkg::PPN_BITS-1:0] page;
        logic                          created;
        logic [31:0]                   leaf;
    } map_reply_t;

    class page_table_board;
        logic [svpm_pkg::PPN_BITS-1:0]  base_pg;
        logic [svpm_pkg::PPN_BITS-1:0]  root_pg;
        logic [svpm_pkg::FREE_BITS-1:0] free_lo;
        logic [svpm_pkg::FREE_BITS-1:0] free_hi;
        logic [svpm_pkg::FREE_BITS-1:0] free_ptr;
        bit [31:0]                      words [svpm_pkg::STORE_PAGES*WORDS_PER_PAGE];
        bit                             known [svpm_pkg::STORE_PAGES*WORDS_PER_PAGE];
        map_reply_t                     replies_due [$];
        int                             errors;
        int                             n_map;
        int                             n_alloc;
        int                             n_tables;
        int                             n_nomem;
        int                             n_settings;

        function new();
            base_pg  = '0;
            root_pg  = '0;
            free_lo  = svpm_pkg::FREE_BITS'(RST_FREE_START);
            free_hi  = svpm_pkg::FREE_BITS'(RST_FREE_END);
            free_ptr = free_lo;
        endfunction

        function bit locate(int unsigned page, int unsigned word, output int unsigned slot);
            slot = 0;
            if (page < base_pg || page - base_pg >= svpm_pkg::STORE_PAGES)
                return 0;
            slot = (page - base_pg) * WORDS_PER_PAGE + word;
            return 1;
        endfunction

        function logic [31:0] fetch(int unsigned page, int unsigned word);
            int unsigned s;
            return locate(page, word, s) ? words[s] : 32'h0;
        endfunction

        function void put_word(int unsigned page, int unsigned word, logic [31:0] v);
            int unsigned s;
            if (locate(page, word, s))
            begin
                words[s] = v;
                known[s] = 1'b1;
            end
        endfunction

        function void wipe(int unsigned page);
            int unsigned s;
            if (locate(page, 0, s))
                for (int i = 0; i < WORDS_PER_PAGE; i++)
                begin
                    words[s+i] = '0;
                    known[s+i] = 1'b1;
                end
        endfunction

        function bit take(int unsigned count, output int unsigned first);
            int unsigned next_ptr;
            next_ptr = free_ptr + count;
            first = 0;
            if (next_ptr > free_hi)
                return 0;
            for (int unsigned i = 0; i < count; i++)
                wipe(free_ptr + i);
            first = free_ptr;
            free_ptr = svpm_pkg::FREE_BITS'(next_ptr);
            return 1;
        endfunction

        function map_reply_t compute_reply(map_cmd_t c);
            map_reply_t  r;
            int unsigned first;
            logic [31:0] entry;
            r = '{svpm_pkg::STAT_OK, '0, 1'b0, '0};
            if (c.op == svpm_pkg::CMD_ALLOC)
            begin
                if (take(c.count, first))
                    r.page = first[svpm_pkg::PPN_BITS-1:0];
                else
                    r.st = svpm_pkg::STAT_NO_MEM;
            end
            else if (c.va[11:0] != '0)
                r.st = svpm_pkg::STAT_VA_UNALIGNED;
            else if (c.pa[11:0] != '0)
                r.st = svpm_pkg::STAT_PA_UNALIGNED;
            else
            begin
                entry = fetch(root_pg, c.va[31:22]);
                if (!entry[0])
                begin
                    if (take(1, first))
                    begin
                        r.page = first[svpm_pkg::PPN_BITS-1:0];
                        put_word(root_pg, c.va[31:22], {r.page, 10'h001});
                        r.created = 1'b1;
                    end
                    else
                        r.st = svpm_pkg::STAT_NO_MEM;
                end
                else
                    r.page = entry[31:10];
                if (r.st == svpm_pkg::STAT_OK)
                begin
                    r.leaf = {2'b00, c.pa[31:12], c.flags} | 32'h1;
                    put_word(r.page, c.va[21:12], r.leaf);
                end
            end
            return r;
        endfunction

        function void log_command(map_cmd_t c);
            map_reply_t r;
            r = compute_reply(c);
            replies_due.push_back(r);
            if (c.op == svpm_pkg::CMD_ALLOC)
                n_alloc++;
            else
                n_map++;
            if (r.created)
                n_tables++;
            if (r.st == svpm_pkg::STAT_NO_MEM)
                n_nomem++;
        endfunction

        function void check_reply(logic [1:0] st, logic [svpm_pkg::PPN_BITS-1:0] page,
                                  logic created, logic [31:0] leaf);
            map_reply_t want;
            if (replies_due.size() == 0)
            begin
                $error("reply with no command outstanding: status %0d page %0d", st, page);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (st !== want.st)
            begin
                $error("status mismatch: expected %0d, got %0d", want.st, st);
                errors++;
            end
            if (page !== want.page)
            begin
                $error("result_page mismatch: expected %0d, got %0d", want.page, page);
                errors++;
            end
            if (created !== want.created)
            begin
                $error("table_created mismatch: expected %0d, got %0d", want.created, created);
                errors++;
            end
            if (leaf !== want.leaf)
            begin
                $error("leaf_entry mismatch: expected %h, got %h", want.leaf, leaf);
                errors++;
            end
        endfunction

        function void apply_reg(logic [svpm_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [svpm_pkg::FREE_BITS-1:0] val);
            case (idx)
                svpm_pkg::CFG_STORE_BASE: base_pg = val[svpm_pkg::PPN_BITS-1:0];
                svpm_pkg::CFG_ROOT_TABLE: root_pg = val[svpm_pkg::PPN_BITS-1:0];
                svpm_pkg::CFG_FREE_START:
                begin
                    free_lo  = val;
                    free_ptr = val;
                end
                svpm_pkg::CFG_FREE_END:   free_hi = val;
                default: ;
            endcase
        endfunction

        // root entries are never read before the page holding them was zeroed
        function bit root_unknown(logic [9:0] vpn1);
            int unsigned s;
            if (!locate(root_pg, vpn1, s))
                return 0;
            return !known[s];
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [svpm_pkg::CFG_IDX_BITS-1:0] cfg_addr;
    logic [svpm_pkg::FREE_BITS-1:0]    cfg_data;
    logic                              start;
    logic                              busy;
    logic                              cmd;
    logic [31:0]                       virt_addr;
    logic [31:0]                       phys_addr;
    logic [9:0]                        perm_flags;
    logic [svpm_pkg::COUNT_BITS-1:0]   page_count;
    logic                              done;
    logic [1:0]                        status;
    logic [svpm_pkg::PPN_BITS-1:0]     result_page;
    logic                              table_created;
    logic [31:0]                       leaf_entry;

    page_table_board sb;
    int              idle_pct;
    int              cycles = 0;
    logic [9:0]      vpn1_pool [6];

    sv32_page_mapper u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .virt_addr     (virt_addr),
        .phys_addr     (phys_addr),
        .perm_flags    (perm_flags),
        .page_count    (page_count),
        .done          (done),
        .status        (status),
        .result_page   (result_page),
        .table_created (table_created),
        .leaf_entry    (leaf_entry)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $error("no finish after %0d cycles", CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_reply(status, result_page, table_created, leaf_entry);

    function automatic map_cmd_t alloc_cmd(int unsigned count);
        map_cmd_t c;
        c.op    = svpm_pkg::CMD_ALLOC;
        c.va    = $urandom;
        c.pa    = $urandom;
        c.flags = 10'($urandom);
        c.count = svpm_pkg::COUNT_BITS'(count);
        return c;
    endfunction

    function automatic map_cmd_t map_cmd(logic [31:0] va, logic [31:0] pa, logic [9:0] flags);
        map_cmd_t c;
        c.op    = svpm_pkg::CMD_MAP;
        c.va    = va;
        c.pa    = pa;
        c.flags = flags;
        c.count = svpm_pkg::COUNT_BITS'($urandom_range(64, 0));
        return c;
    endfunction

    function automatic void fill_pool();
        foreach (vpn1_pool[i])
            vpn1_pool[i] = 10'($urandom);
    endfunction

    // mostly well-formed maps onto a few root slots, so tables fill up and get reused
    function automatic map_cmd_t random_command();
        map_cmd_t    c;
        int unsigned pick;
        int unsigned roll;
        pick = $urandom_range(99, 0);
        roll = $urandom_range(99, 0);
        if (pick < 25)
        begin
            if (roll < 70)
                c = alloc_cmd($urandom_range(2, 0));
            else if (roll < 95)
                c = alloc_cmd($urandom_range(8, 3));
            else
                c = alloc_cmd($urandom_range(64, 9));
        end
        else
        begin
            c = map_cmd($urandom, $urandom, 10'($urandom));
            if (pick < 35)
                c.va[11:0] = 12'($urandom_range(4095, 1));
            else
            begin
                c.va[11:0] = '0;
                if (pick < 45)
                    c.pa[11:0] = 12'($urandom_range(4095, 1));
                else
                begin
                    c.pa[11:0] = '0;
                    if (roll < 90)
                        c.va[31:22] = vpn1_pool[$urandom_range(5, 0)];
                end
            end
        end
        if (c.op == svpm_pkg::CMD_MAP && c.va[11:0] == '0 && c.pa[11:0] == '0 &&
            sb.root_unknown(c.va[31:22]))
            c = alloc_cmd($urandom_range(2, 0));
        return c;
    endfunction

    task automatic push(map_cmd_t c);
        int gap;
        bit pause;
        gap = 0;
        while (gap < 30 && $urandom_range(99, 0) < idle_pct)
            gap++;
        pause = ($urandom_range(99, 0) < 3);
        if (pause || gap > 0)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pause && sb.outstanding() != 0)
                @(posedge clk);
            repeat (gap) @(posedge clk);
        end
        cmd        <= c.op;
        virt_addr  <= c.va;
        phys_addr  <= c.pa;
        perm_flags <= c.flags;
        page_count <= c.count;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.log_command(c);
    endtask

    task automatic run_random(int n);
        repeat (n) push(random_command());
    endtask

    task automatic write_reg(logic [svpm_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= svpm_pkg::FREE_BITS'(val);
        @(posedge clk);
        sb.apply_reg(idx, svpm_pkg::FREE_BITS'(val));
    endtask

    task automatic configure(int unsigned base, int unsigned root, int unsigned lo,
                             int unsigned hi);
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(svpm_pkg::CFG_STORE_BASE, base);
        write_reg(svpm_pkg::CFG_ROOT_TABLE, root);
        write_reg(svpm_pkg::CFG_FREE_START, lo);
        write_reg(svpm_pkg::CFG_FREE_END, hi);
        cfg_wr_en <= 1'b0;
        sb.n_settings++;
    endtask

    // root table is the first page handed out
    task automatic random_phase(int unsigned base, int unsigned lo, int unsigned hi, int n);
        configure(base, lo, lo, hi);
        fill_pool();
        push(alloc_cmd(1));
        run_random(n);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_addr   <= svpm_pkg::CFG_STORE_BASE;
        cfg_data   <= '0;
        start      <= 1'b0;
        cmd        <= svpm_pkg::CMD_MAP;
        virt_addr  <= '0;
        phys_addr  <= '0;
        perm_flags <= '0;
        page_count <= '0;
        sb = new();
        idle_pct = 17;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: root page never zeroed, so maps only take fault paths
        push(alloc_cmd(0));
        push(alloc_cmd(1));
        push(alloc_cmd(64));
        push(map_cmd(32'h0000_0800, 32'h0000_0000, 10'h3ff));
        push(map_cmd(32'h0000_0000, 32'h0000_0800, 10'h000));
        push(map_cmd(32'hffff_ffff, 32'hffff_ffff, 10'h155));

        configure(0, 5, 5, 40);
        push(alloc_cmd(1));
        push(map_cmd(32'h0000_0000, 32'h0000_0000, 10'h000));
        push(map_cmd(32'h0000_1000, 32'h1234_5000, 10'h2cf));
        push(map_cmd(32'hffff_f000, 32'hffff_f000, 10'h3ff));
        push(map_cmd(32'hffc0_0000, 32'h0000_0000, 10'h3fe));
        push(alloc_cmd(3));
        push(map_cmd(32'h0040_0123, 32'h0000_1000, 10'h0aa));
        push(map_cmd(32'h0040_0000, 32'h0000_0fff, 10'h001));
        push(alloc_cmd(64));

        random_phase(0, 0, 28, 130);
        idle_pct = 85;
        random_phase(1000, 1010, 1100, 130);
        // root table outside the store: every aligned map needs a fresh table
        configure(2000000, 100, 2000040, 2000080);
        fill_pool();
        push(alloc_cmd(1));
        run_random(100);
        idle_pct = 0;

        configure(MAX_PAGE, MAX_PAGE, MAX_PAGE, MAX_FREE);
        push(alloc_cmd(1));
        push(map_cmd(32'h1234_5000, 32'h0000_1000, 10'h0f0));
        push(alloc_cmd(0));

        configure(MAX_PAGE - 1, MAX_PAGE - 1, MAX_PAGE - 1, MAX_FREE);
        push(alloc_cmd(1));
        push(map_cmd(32'h4012_3000, 32'habcd_e000, 10'h0ff));
        push(map_cmd(32'h4000_0000, 32'h0000_0000, 10'h100));
        push(map_cmd(32'h8000_1000, 32'h0000_2000, 10'h000));
        push(alloc_cmd(0));
        fill_pool();
        vpn1_pool[0] = 10'h100;
        vpn1_pool[1] = 10'h200;
        run_random(60);

        configure(0, 5, MAX_FREE, MAX_FREE);
        push(alloc_cmd(0));
        push(alloc_cmd(1));
        push(map_cmd(32'h0000_0000, 32'h0000_0000, 10'h155));
        run_random(20);

        configure(0, MAX_PAGE, 0, 0);
        push(alloc_cmd(0));
        push(alloc_cmd(1));
        push(map_cmd(32'h0080_3000, 32'h0040_0000, 10'h2aa));
        run_random(20);

        random_phase(3000, 3000, 3020, 100);

        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("ran %0d maps (%0d new tables) and %0d allocates over %0d register settings",
                 sb.n_map, sb.n_tables, sb.n_alloc, sb.n_settings);
        $display("%0d replies were out of memory; %0d field mismatches", sb.n_nomem, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sv32_page_mapper.f @@
hdl/svpm_pkg.sv
hdl/svpm_page_store.sv
hdl/sv32_page_mapper.sv
tb/testbench.sv
